// ===== src/cbt_pkg.sv =====
// Shared types, constants and the backoff length function for the CSMA/CD
// backoff transmitter. No dependencies; used by every other file in src but cbt_checker.
`default_nettype none

package cbt_pkg;

   localparam int TIMER_W             = 11;
   localparam int RETRY_W             = 5;
   localparam int RANDOM_W            = 16;
   localparam int LIMIT_W             = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int REQ_TDATA_W         = 24;
   localparam int RSP_TDATA_W         = 16;
   localparam int CSR_INDEX_W         = 1;
   localparam int CSR_DATA_W          = 4;

   localparam logic [TIMER_W-1:0] TIMER_MAX         = 11'd2047;
   localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RESET = 4'd15;
   localparam logic [LIMIT_W-1:0] BACKOFF_CAP_RESET = 4'd10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RETRY_LIMIT = 1'b0,
      CSR_BACKOFF_CAP = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] retry_limit;
      logic [LIMIT_W-1:0] backoff_cap;
   } cfg_type;

   typedef struct packed {
      logic [RANDOM_W-1:0] random_value;
      logic                bus_free;
      logic                bus_jammed;
      logic                new_frame;
   } item_type;

   typedef struct packed {
      logic [TIMER_W-1:0] timer;
      logic [RETRY_W-1:0] retry;
      logic               sending;
   } core_type;

   typedef struct packed {
      logic [RETRY_W-1:0] retries;
      logic               idle;
      logic               queue_overflow;
      logic               gave_up;
      logic               finished;
      logic               start_send;
   } result_type;

   // Ticks of backoff: (rnd * (2^min(cap, retry) + 1)) >> RANDOM_W, saturated.
   function automatic logic [TIMER_W-1:0] backoff_len(
      input logic [RANDOM_W-1:0] rnd,
      input logic [RETRY_W-1:0]  retry,
      input logic [LIMIT_W-1:0]  cap
   );
      logic [LIMIT_W-1:0]    expo;
      logic [2*RANDOM_W-1:0] prod;
      logic [RANDOM_W-1:0]   len;
      expo = (retry < {1'b0, cap}) ? retry[LIMIT_W-1:0] : cap;
      prod = ({{RANDOM_W{1'b0}}, rnd} << expo) + {{RANDOM_W{1'b0}}, rnd};
      len  = prod[2*RANDOM_W-1:RANDOM_W];
      return (len > {{(RANDOM_W-TIMER_W){1'b0}}, TIMER_MAX}) ? TIMER_MAX
                                                             : len[TIMER_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/csma_cd_backoff_transmitter_unit.sv =====
// A word taken on req is held in the input register, then loaded into the
// result register and offered on rsp from then on.
// Throughput: one word per cycle while rsp is not stalled; state advances in the edge that loads the
// result, and a stalled rsp holds both the input and the result register.
// Reset (synchronous, active high) clears state, queue count and valids and
// restores retry_limit to 15 and backoff_cap to 10.
`default_nettype none

module csma_cd_backoff_transmitter_unit #(
   parameter int QUEUE_DEPTH = cbt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // new_frame[0], bus_jammed[1], bus_free[2], random_value[18:3], zero fill
   input  wire logic [cbt_pkg::REQ_TDATA_W-1:0] req_tdata,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // start_send[0], finished[1], gave_up[2], queue_overflow[3], idle[4],
   // retries[9:5], zero fill
   output      logic [cbt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [cbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [cbt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PEND_W = $clog2(QUEUE_DEPTH + 1);

   cbt_pkg::cfg_type    cfg_ff;
   cbt_pkg::item_type   item_ff;
   logic                in_valid_ff;
   cbt_pkg::core_type   core_ff;
   cbt_pkg::core_type   core_in;
   logic [PEND_W-1:0]   pend_ff;
   logic [PEND_W-1:0]   pend_in;
   cbt_pkg::result_type res_in;
   cbt_pkg::result_type res_ff;
   logic                out_valid_ff;
   logic                advance;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(cbt_pkg::RSP_TDATA_W - $bits(cbt_pkg::result_type)){1'b0}}, res_ff};

   cbt_step #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_step (
      .cfg      (cfg_ff),
      .item     (item_ff),
      .cur      (core_ff),
      .pend     (pend_ff),
      .nxt      (core_in),
      .pend_nxt (pend_in),
      .res      (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit <= cbt_pkg::RETRY_LIMIT_RESET;
         cfg_ff.backoff_cap <= cbt_pkg::BACKOFF_CAP_RESET;
      end else if (csr_valid) begin
         unique case (cbt_pkg::csr_index_type'(csr_index))
            cbt_pkg::CSR_RETRY_LIMIT: cfg_ff.retry_limit <= csr_wdata;
            cbt_pkg::CSR_BACKOFF_CAP: cfg_ff.backoff_cap <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         core_ff      <= '0;
         pend_ff      <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            core_ff      <= core_in;
            pend_ff      <= pend_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: item loads on req handshake, result on advance, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_tdata[$bits(cbt_pkg::item_type)-1:0];
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/cbt_step.sv =====
// Send rule of the backoff transmitter: next state and result for one tick.
// Depends on cbt_pkg.
`default_nettype none

module cbt_step #(
   parameter int QUEUE_DEPTH = cbt_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int PEND_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  cbt_pkg::cfg_type    cfg,
   input  cbt_pkg::item_type   item,
   input  cbt_pkg::core_type   cur,
   input  logic [PEND_W-1:0]   pend,
   output cbt_pkg::core_type   nxt,
   output logic [PEND_W-1:0]   pend_nxt,
   output cbt_pkg::result_type res
);

   logic [PEND_W-1:0]          pend_q;
   logic [PEND_W-1:0]          pend_dec;
   logic [PEND_W-1:0]          head_pend;
   logic                       ovf;
   logic                       launch;
   logic                       done;
   logic                       dropped;
   logic                       bo_start;
   logic [cbt_pkg::RETRY_W-1:0] retry_inc;
   logic [cbt_pkg::RETRY_W-1:0] bo_retry;
   logic [cbt_pkg::TIMER_W-1:0] bo_len;

   // count the newly queued frame, saturating at the queue depth
   always_comb begin
      ovf    = 1'b0;
      pend_q = pend;
      if (item.new_frame) begin
         if (pend >= PEND_W'(QUEUE_DEPTH)) begin
            ovf = 1'b1;
         end else begin
            pend_q = pend + PEND_W'(1);
         end
      end
   end

   assign pend_dec  = (pend_q != '0) ? pend_q - PEND_W'(1) : pend_q;
   assign retry_inc = cur.retry + cbt_pkg::RETRY_W'(1);

   // exponent source: bumped count after a jam, zero after a finish
   assign bo_retry = (cur.sending && item.bus_jammed) ? retry_inc :
                     (cur.sending ? '0 : cur.retry);
   assign bo_len   = cbt_pkg::backoff_len(item.random_value, bo_retry, cfg.backoff_cap);

   always_comb begin
      nxt       = cur;
      pend_nxt  = pend_q;
      head_pend = pend_q;
      launch    = 1'b0;
      done      = 1'b0;
      dropped   = 1'b0;
      bo_start  = 1'b0;
      if (cur.timer != '0) begin
         nxt.timer = cur.timer - cbt_pkg::TIMER_W'(1);
      end else if (cur.sending && item.bus_jammed) begin
         nxt.sending = 1'b0;
         if (retry_inc > {1'b0, cfg.retry_limit}) begin
            nxt.retry = '0;
            pend_nxt  = pend_dec;
            dropped   = 1'b1;
         end else begin
            nxt.retry = retry_inc;
            bo_start  = 1'b1;
         end
      end else if (cur.sending && !item.bus_free) begin
         // hold: frame stays on the bus
         nxt = cur;
      end else begin
         if (cur.sending) begin
            done        = 1'b1;
            nxt.sending = 1'b0;
            nxt.retry   = '0;
            head_pend   = pend_dec;
         end
         pend_nxt = head_pend;
         if (head_pend != '0) begin
            if (item.bus_free) begin
               nxt.sending = 1'b1;
               launch      = 1'b1;
            end else begin
               bo_start = 1'b1;
            end
         end
      end
      if (bo_start) begin
         nxt.timer = bo_len;
      end
   end

   always_comb begin
      res.start_send     = launch;
      res.finished       = done;
      res.gave_up        = dropped;
      res.queue_overflow = ovf;
      res.idle           = (nxt.timer == '0) && !nxt.sending && (pend_nxt == '0);
      res.retries        = nxt.retry;
   end

endmodule

`default_nettype wire

// ===== src/cbt_checker.sv =====
// Port-level checks for csma_cd_backoff_transmitter_unit, bound to the top
// level below. Depends only on the top level's ports.
`default_nettype none

module cbt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word withdrawn while stalled");

   // no word may leave right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // dropping the head frame clears the retry count
   a_drop_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[9:5] == 5'd0)
      else $error("retries nonzero after drop");

   // a launched frame is on the bus, so the station is not idle and no drop is reported
   a_launch_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[4] && !rsp_tdata[2])
      else $error("idle or drop reported with launch");

endmodule

bind csma_cd_backoff_transmitter_unit cbt_checker u_cbt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for csma_cd_backoff_transmitter_unit: streams bus ticks
// and checks every result word against a cycle-free model of the send rule.
// Depends on src/cbt_pkg.sv and src/csma_cd_backoff_transmitter_unit.sv.
`timescale 1ns / 100ps

module tb;

   localparam int HOLD_AT     = 1100;
   localparam int HOLD_CYCLES = 150;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [cbt_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [cbt_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   cbt_pkg::csr_index_type          csr_index  = cbt_pkg::CSR_RETRY_LIMIT;
   logic [cbt_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   // model state, reset values of the block
   logic [cbt_pkg::LIMIT_W-1:0] m_limit   = cbt_pkg::RETRY_LIMIT_RESET;
   logic [cbt_pkg::LIMIT_W-1:0] m_cap     = cbt_pkg::BACKOFF_CAP_RESET;
   logic [cbt_pkg::TIMER_W-1:0] m_timer   = '0;
   logic [cbt_pkg::RETRY_W-1:0] m_retry   = '0;
   logic                        m_sending = 1'b0;
   int                          m_pending = 0;

   cbt_pkg::item_type   tick_q[$];
   cbt_pkg::result_type outcome_q[$];
   bit                  steady     = 1'b0;
   int                  errors     = 0;
   int                  words_seen = 0;
   int                  hold_left  = 0;

   csma_cd_backoff_transmitter_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [cbt_pkg::TIMER_W-1:0] backoff_ticks(
      logic [cbt_pkg::RANDOM_W-1:0] rnd
   );
      int unsigned     expo;
      longint unsigned span;
      longint unsigned len;
      expo = 32'((m_retry < {1'b0, m_cap}) ? m_retry : {1'b0, m_cap});
      span = (64'd1 << expo) + 64'd1;
      len  = (64'(rnd) * span) >> cbt_pkg::RANDOM_W;
      return (len > 64'(cbt_pkg::TIMER_MAX)) ? cbt_pkg::TIMER_MAX
                                             : len[cbt_pkg::TIMER_W-1:0];
   endfunction

   // one bus tick of the transmitter; updates the model state
   function automatic cbt_pkg::result_type advance_tick(cbt_pkg::item_type it);
      cbt_pkg::result_type res;
      res = '0;
      if (it.new_frame) begin
         if (m_pending >= cbt_pkg::QUEUE_DEPTH_DEFAULT) res.queue_overflow = 1'b1;
         else m_pending++;
      end
      if (m_timer != 0) begin
         m_timer--;
      end else if (m_sending && it.bus_jammed) begin
         // jam wins over free
         m_sending = 1'b0;
         m_retry   = m_retry + 1'b1;
         if (m_retry > {1'b0, m_limit}) begin
            m_retry = '0;
            if (m_pending != 0) m_pending--;
            res.gave_up = 1'b1;
         end else begin
            m_timer = backoff_ticks(it.random_value);
         end
      end else if (!m_sending || it.bus_free) begin
         if (m_sending) begin
            m_sending = 1'b0;
            m_retry   = '0;
            if (m_pending != 0) m_pending--;
            res.finished = 1'b1;
         end
         // next head may go out in the same tick
         if (m_pending != 0) begin
            if (it.bus_free) begin
               m_sending      = 1'b1;
               res.start_send = 1'b1;
            end else begin
               m_timer = backoff_ticks(it.random_value);
            end
         end
      end
      res.idle    = (m_timer == 0) && !m_sending && (m_pending == 0);
      res.retries = m_retry;
      return res;
   endfunction

   function automatic void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         errors++;
      end
   endfunction

   function automatic void queue_tick(bit nf, bit jam, bit bus_free,
                                      logic [cbt_pkg::RANDOM_W-1:0] rnd);
      cbt_pkg::item_type t;
      t.new_frame    = nf;
      t.bus_jammed   = jam;
      t.bus_free     = bus_free;
      t.random_value = rnd;
      tick_q.push_back(t);
   endfunction

   function automatic cbt_pkg::item_type random_tick();
      cbt_pkg::item_type t;
      int                pick;
      int                spread;
      pick   = $urandom_range(0, 99);
      spread = $urandom_range(0, 99);
      t.new_frame  = ($urandom_range(0, 99) < 30);
      t.bus_jammed = (pick < 20);
      t.bus_free   = (pick >= 55) || (pick < 20 && $urandom_range(0, 1) == 1);
      // keep most backoffs short so frames keep moving
      if (spread < 70)      t.random_value = 16'($urandom_range(0, 255));
      else if (spread < 92) t.random_value = 16'($urandom);
      else if (spread < 96) t.random_value = 16'hFFFF;
      else                  t.random_value = 16'h0000;
      return t;
   endfunction

   // feed ticks from the queue
   always @(posedge clock) begin : feed
      cbt_pkg::item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            outcome_q.push_back(advance_tick(
               cbt_pkg::item_type'(req_tdata[$bits(cbt_pkg::item_type)-1:0])));
         if (!req_tvalid || req_tready) begin
            if (tick_q.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
               nxt = tick_q.pop_front();
               req_tdata  <= {{(cbt_pkg::REQ_TDATA_W - $bits(cbt_pkg::item_type)){1'b0}},
                              nxt};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // check result words, hold off once so the block backs up
   always @(posedge clock) begin : watch
      cbt_pkg::result_type got;
      cbt_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = cbt_pkg::result_type'(rsp_tdata[$bits(cbt_pkg::result_type)-1:0]);
            words_seen++;
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = outcome_q.pop_front();
               check_field("start_send", want.start_send, got.start_send);
               check_field("finished", want.finished, got.finished);
               check_field("gave_up", want.gave_up, got.gave_up);
               check_field("queue_overflow", want.queue_overflow, got.queue_overflow);
               check_field("idle", want.idle, got.idle);
               check_field("retries", want.retries, got.retries);
            end
            if (words_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 24);
         end
      end
   end

   task automatic drain();
      while (tick_q.size() != 0 || req_tvalid || outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(cbt_pkg::csr_index_type idx,
                            logic [cbt_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         cbt_pkg::CSR_RETRY_LIMIT: m_limit = val;
         cbt_pkg::CSR_BACKOFF_CAP: m_cap   = val;
         default: ;
      endcase
   endtask

   task automatic run_phase(int count);
      for (int k = 0; k < count; k++) tick_q.push_back(random_tick());
      drain();
   endtask

   initial begin : sequencer
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      queue_tick(1'b0, 1'b0, 1'b0, 16'h0000);
      queue_tick(1'b1, 1'b0, 1'b1, 16'h0000);   // launch
      queue_tick(1'b0, 1'b1, 1'b1, 16'hFFFF);   // jam and free together
      queue_tick(1'b0, 1'b0, 1'b0, 16'h0000);
      queue_tick(1'b0, 1'b0, 1'b0, 16'h0000);
      queue_tick(1'b0, 1'b0, 1'b0, 16'h0000);   // busy bus, zero-length backoff
      queue_tick(1'b0, 1'b0, 1'b1, 16'h0000);
      queue_tick(1'b0, 1'b0, 1'b0, 16'h0000);   // stay on the bus
      queue_tick(1'b1, 1'b0, 1'b1, 16'h0000);   // finish and relaunch
      // fill the queue past its depth
      for (int k = 0; k < 16; k++) queue_tick(1'b1, 1'b0, 1'b0, 16'h0000);
      drain();

      csr_write(cbt_pkg::CSR_RETRY_LIMIT, 4'd0);
      csr_write(cbt_pkg::CSR_BACKOFF_CAP, 4'd0);
      run_phase(200);
      csr_write(cbt_pkg::CSR_RETRY_LIMIT, 4'd3);
      csr_write(cbt_pkg::CSR_BACKOFF_CAP, 4'd2);
      run_phase(250);
      csr_write(cbt_pkg::CSR_RETRY_LIMIT, 4'd15);
      csr_write(cbt_pkg::CSR_BACKOFF_CAP, 4'd15);
      run_phase(250);
      csr_write(cbt_pkg::CSR_RETRY_LIMIT, 4'd6);
      csr_write(cbt_pkg::CSR_BACKOFF_CAP, 4'd10);
      run_phase(250);
      csr_write(cbt_pkg::CSR_RETRY_LIMIT, 4'd15);
      csr_write(cbt_pkg::CSR_BACKOFF_CAP, 4'd3);
      steady = 1'b1;
      run_phase(300);

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/cbt_pkg.sv
src/cbt_step.sv
src/csma_cd_backoff_transmitter_unit.sv
src/cbt_checker.sv
bench/tb.sv
